// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on the rising edge, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every sampled edge outside reset.
`define BMVA_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Expression must never be true outside reset.
`define BMVA_NEVER(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// ===== design/bmva_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmva_pkg
// Shared constants and codes for the border-mode voxel address generator.
// ----------------------------------------------------------------------------
package bmva_pkg;

    localparam int MAX_DIM_DEF    = 4096;
    localparam int COORD_BITS_DEF = 16;

    localparam int CFG_W     = 13;  // widest config register
    localparam int CFG_IDX_W = 2;
    localparam int MODE_W    = 2;
    localparam int IDX_W     = 36;  // element index width

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIZE_X      = 2'd0,
        REG_SIZE_Y      = 2'd1,
        REG_SIZE_Z      = 2'd2,
        REG_BORDER_MODE = 2'd3
    } cfg_reg_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_NONE      = 2'd0,
        MODE_REFLECT   = 2'd1,
        MODE_WRAP      = 2'd2,
        MODE_REPLICATE = 2'd3
    } border_mode_t;

endpackage

// ===== design/border_mode_voxel_address.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// border_mode_voxel_address
// Maps a signed 3-D voxel coordinate into the volume by border mode and
// returns its linear element index z*sx*sy + y*sx + x.
// ----------------------------------------------------------------------------
// Pipeline: input register, remainder pipeline (one quotient bit per stage),
//   fold stage, index stages m1 and m2, then the result register; done
//   strobes for one cycle.
// Throughput: one request per cycle; busy stays low, the results never stall.
// Reset (rst_n low, async): sizes return to 1, mode to none, pipeline empties.
// ----------------------------------------------------------------------------
module border_mode_voxel_address #(
    parameter int MAX_DIM    = bmva_pkg::MAX_DIM_DEF,
    parameter int COORD_BITS = bmva_pkg::COORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_write,
    input  bmva_pkg::cfg_reg_t               cfg_index,
    input  logic [bmva_pkg::CFG_W-1:0]       cfg_data,
    // request side
    input  logic                             start,
    output logic                             busy,
    input  logic signed [COORD_BITS-1:0]     coord_x,
    input  logic signed [COORD_BITS-1:0]     coord_y,
    input  logic signed [COORD_BITS-1:0]     coord_z,
    // result side
    output logic                             done,
    output logic [bmva_pkg::IDX_W-1:0]       element_index,
    output logic                             outside
);
    import bmva_pkg::*;

    localparam int NAX      = 3;                                  // x, y, z
    localparam int CB       = COORD_BITS;
    localparam int CW       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1; // in-volume coord
    localparam int SW       = $clog2(MAX_DIM + 1);                // effective size
    localparam int DW       = $clog2(2 * MAX_DIM);                // divisor, up to 2s-1
    localparam int CMPW     = (CB > SW) ? CB : SW;                // range compare
    localparam int PW1      = CW + SW;                            // y*sx, z*sx
    localparam int YXW      = PW1 + 1;                            // y*sx + x
    localparam int PW2      = CW + 2 * SW;                        // z*sx*sy
    localparam int SUMW_RAW = PW2 + 1;
    localparam int SUMW     = (SUMW_RAW > IDX_W) ? SUMW_RAW : IDX_W;

    // Per-axis payload of the remainder pipeline.
    typedef struct packed {
        logic [DW-1:0] rem;   // partial remainder
        logic [CB-1:0] dvd;   // dividend bits still to shift in, MSB first
        logic          neg;   // coordinate was negative
        logic          oor;   // out of range for mode none
        logic [CW-1:0] dir;   // result for modes none / replicate
    } dax_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] size_reg [NAX];
    border_mode_t     mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NAX; a++)
            begin
                size_reg[a] <= CFG_W'(1);
            end
            mode_reg <= MODE_NONE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SIZE_X:      size_reg[0] <= cfg_data;
                REG_SIZE_Y:      size_reg[1] <= cfg_data;
                REG_SIZE_Z:      size_reg[2] <= cfg_data;
                REG_BORDER_MODE: mode_reg    <= border_mode_t'(cfg_data[MODE_W-1:0]);
                default:         ;
            endcase
        end
    end

    // Effective size (0 acts as 1, clamp at MAX_DIM) and the divisor the
    // mode needs: reflect folds over a period of 2s-1, wrap over s.
    // Registered so no request sees the clamp and doubling in its path;
    // a request taken right after a write still sees the new value.
    logic [SW-1:0] seff_next [NAX];
    logic [SW-1:0] seff_reg  [NAX];
    logic [DW-1:0] dvs_next  [NAX];
    logic [DW-1:0] dvs_reg   [NAX];

    always_comb
    begin
        for (int a = 0; a < NAX; a++)
        begin
            if (size_reg[a] == '0)
                seff_next[a] = SW'(1);
            else if (32'(size_reg[a]) > MAX_DIM)
                seff_next[a] = SW'(MAX_DIM);
            else
                seff_next[a] = SW'(size_reg[a]);

            if (mode_reg == MODE_REFLECT)
                dvs_next[a] = DW'({seff_next[a], 1'b0} - (SW + 1)'(1));
            else
                dvs_next[a] = DW'(seff_next[a]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NAX; a++)
            begin
                seff_reg[a] <= SW'(1);
                dvs_reg[a]  <= DW'(1);
            end
        end
        else
        begin
            seff_reg <= seff_next;
            dvs_reg  <= dvs_next;
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic                  in_vld_reg;
    logic signed [CB-1:0]  in_crd_reg [NAX];

    assign busy = 1'b0;   // fully pipelined, never holds a request off

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_crd_reg[0] <= coord_x;
            in_crd_reg[1] <= coord_y;
            in_crd_reg[2] <= coord_z;
        end
    end

    // ------------------------------------------------------------------
    // Remainder pipeline. Stage 0 takes the magnitude and resolves the
    // clamp / range check; stages 1..CB each shift in one dividend bit
    // and do one compare-subtract (restoring division, remainder only).
    // ------------------------------------------------------------------
    logic [CB:0] dv_vld_reg;
    dax_t        dv_next [CB+1][NAX];
    dax_t        dv_reg  [CB+1][NAX];

    always_comb
    begin
        logic [CB-1:0]   crd_u;
        logic [CMPW-1:0] v_ext;
        logic            neg;
        logic            ge;
        logic [DW:0]     sh;
        logic [DW:0]     dvs_ext;

        for (int a = 0; a < NAX; a++)
        begin
            crd_u = in_crd_reg[a];
            neg   = crd_u[CB-1];
            v_ext = CMPW'(crd_u);
            ge    = v_ext >= CMPW'(seff_reg[a]);

            dv_next[0][a].rem = '0;
            dv_next[0][a].dvd = neg ? (~crd_u + CB'(1)) : crd_u;   // |v|
            dv_next[0][a].neg = neg;
            dv_next[0][a].oor = neg || ge;
            if (neg)
                dv_next[0][a].dir = '0;
            else if (ge)
                dv_next[0][a].dir = (mode_reg == MODE_NONE) ? '0 :
                                    CW'(seff_reg[a] - SW'(1));
            else
                dv_next[0][a].dir = CW'(v_ext);
        end

        for (int k = 1; k <= CB; k++)
        begin
            for (int a = 0; a < NAX; a++)
            begin
                dv_next[k][a] = dv_reg[k-1][a];
                dvs_ext = {1'b0, dvs_reg[a]};
                sh      = {dv_reg[k-1][a].rem, dv_reg[k-1][a].dvd[CB-1]};
                if (sh >= dvs_ext)
                    dv_next[k][a].rem = DW'(sh - dvs_ext);
                else
                    dv_next[k][a].rem = DW'(sh);
                dv_next[k][a].dvd = dv_reg[k-1][a].dvd << 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_vld_reg <= '0;
        else
            dv_vld_reg <= {dv_vld_reg[CB-1:0], in_vld_reg};
    end

    always_ff @(posedge clk)
    begin
        dv_reg <= dv_next;
    end

    // ------------------------------------------------------------------
    // Fold stage: turn the remainder into the in-volume coordinate.
    //   reflect: r < s ? r : (2s-1) - r
    //   wrap:    negative input with nonzero r gives s - r
    //   none / replicate: taken from stage 0
    // ------------------------------------------------------------------
    logic          fd_vld_reg;
    logic [CW-1:0] fd_crd_next [NAX];
    logic [CW-1:0] fd_crd_reg  [NAX];
    logic          fd_out_next;
    logic          fd_out_reg;

    always_comb
    begin
        logic [DW-1:0] r;
        logic [DW-1:0] s_ext;

        fd_out_next = 1'b0;
        for (int a = 0; a < NAX; a++)
        begin
            r     = dv_reg[CB][a].rem;
            s_ext = DW'(seff_reg[a]);
            case (mode_reg)
                MODE_REFLECT:
                    fd_crd_next[a] = (r < s_ext) ? CW'(r) : CW'(dvs_reg[a] - r);
                MODE_WRAP:
                    fd_crd_next[a] = (dv_reg[CB][a].neg && (r != '0)) ?
                                     CW'(s_ext - r) : CW'(r);
                default:
                    fd_crd_next[a] = dv_reg[CB][a].dir;
            endcase
            if (mode_reg == MODE_NONE && dv_reg[CB][a].oor)
                fd_out_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fd_vld_reg <= 1'b0;
        else
            fd_vld_reg <= dv_vld_reg[CB];
    end

    always_ff @(posedge clk)
    begin
        fd_crd_reg <= fd_crd_next;
        fd_out_reg <= fd_out_next;
    end

    // ------------------------------------------------------------------
    // Index: z*sx and y*sx, then (z*sx)*sy and y*sx + x, then the sum.
    // ------------------------------------------------------------------
    logic           m1_vld_reg;
    logic [PW1-1:0] m1_zsx_reg;
    logic [PW1-1:0] m1_ysx_reg;
    logic [CW-1:0]  m1_x_reg;
    logic           m1_out_reg;

    logic           m2_vld_reg;
    logic [PW2-1:0] m2_zxy_reg;
    logic [YXW-1:0] m2_yx_reg;
    logic           m2_out_reg;

    logic [SUMW-1:0]  idx_sum;
    logic             done_reg;
    logic [IDX_W-1:0] element_index_reg;
    logic             outside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
        end
        else
        begin
            m1_vld_reg <= fd_vld_reg;
            m2_vld_reg <= m1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_zsx_reg <= PW1'(fd_crd_reg[2]) * PW1'(seff_reg[0]);
        m1_ysx_reg <= PW1'(fd_crd_reg[1]) * PW1'(seff_reg[0]);
        m1_x_reg   <= fd_crd_reg[0];
        m1_out_reg <= fd_out_reg;

        m2_zxy_reg <= PW2'(m1_zsx_reg) * PW2'(seff_reg[1]);
        m2_yx_reg  <= YXW'(m1_ysx_reg) + YXW'(m1_x_reg);
        m2_out_reg <= m1_out_reg;
    end

    assign idx_sum = SUMW'(m2_zxy_reg) + SUMW'(m2_yx_reg);

    // Result register: payload reads zero between strobes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg          <= 1'b0;
            element_index_reg <= '0;
            outside_reg       <= 1'b0;
        end
        else
        begin
            done_reg          <= m2_vld_reg;
            element_index_reg <= (m2_vld_reg && !m2_out_reg) ? idx_sum[IDX_W-1:0] : '0;
            outside_reg       <= m2_vld_reg && m2_out_reg;
        end
    end

    assign done          = done_reg;
    assign element_index = element_index_reg;
    assign outside       = outside_reg;

endmodule

// ===== design/bmva_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmva_checker
// Port-level checks on request-to-result timing and result encoding.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmva_checker #(
    parameter int LAT = bmva_pkg::COORD_BITS_DEF + 6
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic [bmva_pkg::IDX_W-1:0] element_index,
    input logic                       outside
);
    import bmva_pkg::*;

    `BMVA_ASSERT(a_req_gives_result, clk, rst_n, (start && !busy) |-> ##LAT done, "request produced no result at fixed latency")
    `BMVA_ASSERT(a_result_has_req, clk, rst_n, done |-> $past(start && !busy, LAT), "result without a matching request")
    `BMVA_ASSERT(a_outside_zero, clk, rst_n, outside |-> (element_index == '0), "outside result with nonzero index")
    `BMVA_NEVER(a_idle_quiet, clk, rst_n, !done && (outside || (element_index != '0)), "result payload active without strobe")

endmodule

bind border_mode_voxel_address bmva_checker #(
    .LAT(COORD_BITS + 6)
) u_bmva_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .element_index(element_index),
    .outside      (outside)
);
